>>> rtl/glsig_pkg.sv
// Shared types, constants and codes for the grid luma signature block.
// Used by the controller, the datapath, the top level and the checker.
package glsig_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam int CH_W         = 8;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CELLS        = 16;
  localparam int CELL_W       = 4;
  localparam int LUMA_W       = 24;
  localparam int Q_W          = 17;
  localparam int DIV_STEPS    = Q_W;
  localparam int STEP_W       = 5;

  localparam logic [Q_W-1:0]       Q_ONE      = 17'h10000;
  localparam logic [15:0]          WEIGHT_R   = 16'd13933;
  localparam logic [15:0]          WEIGHT_G   = 16'd46871;
  localparam logic [15:0]          WEIGHT_B   = 16'd4732;
  localparam logic [CFG_W-1:0]     SIDE_RESET = 8'd96;
  localparam logic [CELL_W-1:0]    CELL_LAST  = 4'd15;
  localparam logic [STEP_W-1:0]    STEP_LAST  = 5'(DIV_STEPS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } glsig_state_t;

  typedef struct packed {
    logic              accept;
    logic              load;
    logic              prep;
    logic              step;
    logic              emit;
    logic              last;
    logic [CELL_W-1:0] cell_k;
  } glsig_cmd_t;

  typedef struct packed {
    logic frame_end;
  } glsig_stat_t;

endpackage

>>> rtl/glsig_ctrl.sv
// Controller of the grid luma signature block: request acceptance and
// the per-cell readout sequence. Depends on glsig_pkg.
module glsig_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  glsig_pkg::glsig_stat_t stat,
  output glsig_pkg::glsig_cmd_t  cmd
);
  import glsig_pkg::*;

  glsig_state_t      state_r, state_nxt;
  logic [CELL_W-1:0] cell_k_r, cell_k_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cell_k_r <= '0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cell_k_r <= cell_k_nxt;
      step_r   <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    cell_k_nxt = cell_k_r;
    step_nxt   = step_r;
    case (state_r)
      ST_IDLE: begin
        cell_k_nxt = '0;
        if (accept && stat.frame_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_PREP;
      ST_PREP: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cell_k_nxt = cell_k_r + 1'b1;
        state_nxt  = (cell_k_r == CELL_LAST) ? ST_IDLE : ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy       = 1'b1;
    cmd        = '0;
    cmd.cell_k = cell_k_r;
    cmd.last   = (cell_k_r == CELL_LAST);
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = accept;
      end
      ST_LOAD:  cmd.load = 1'b1;
      ST_PREP:  cmd.prep = 1'b1;
      ST_DIV:   cmd.step = 1'b1;
      ST_EMIT:  cmd.emit = 1'b1;
      default:  busy     = 1'b1;
    endcase
  end

endmodule

>>> rtl/glsig_dp.sv
// Datapath of the grid luma signature block: size registers, raster
// counters, cell sums and counts, and the shared restoring divider.
// Depends on glsig_pkg.
module glsig_dp #(
  parameter int MAX_SIDE = glsig_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  glsig_pkg::glsig_cmd_t             cmd,
  output glsig_pkg::glsig_stat_t            stat,
  input  logic                              cfg_wr,
  input  logic [glsig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glsig_pkg::CFG_W-1:0]       cfg_data,
  input  logic [glsig_pkg::CH_W-1:0]        in_red,
  input  logic [glsig_pkg::CH_W-1:0]        in_green,
  input  logic [glsig_pkg::CH_W-1:0]        in_blue,
  output logic                              out_valid,
  output logic [glsig_pkg::CELL_W-1:0]      out_cell_index,
  output logic [glsig_pkg::Q_W-1:0]         out_mean_luma,
  output logic                              out_last_cell
);
  import glsig_pkg::*;

  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = SIDE_W + 2;
  localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUM_W  = CNT_W + LUMA_W;
  localparam int DEN_W  = CNT_W + 8;
  localparam int REM_W  = SUM_W + 1;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) s = SIDE_W'(1);
    else if (int'(v) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
    else s = SIDE_W'(v);
    return s;
  endfunction

  function automatic logic [1:0] cell_of(input logic [POS_W-1:0] pos,
                                         input logic [SIDE_W-1:0] side);
    logic [CMP_W-1:0] p4;
    logic [CMP_W-1:0] s1;
    logic [1:0]       c;
    p4 = CMP_W'(pos) << 2;
    s1 = CMP_W'(side);
    if (p4 >= 3 * s1) c = 2'd3;
    else if (p4 >= 2 * s1) c = 2'd2;
    else if (p4 >= s1) c = 2'd1;
    else c = 2'd0;
    return c;
  endfunction

  // configuration
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RESET;
      height_r <= SIDE_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // raster counters and cell placement
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0]  col_r, row_r;
  logic [SIDE_W-1:0] col_inc, row_inc;
  logic              row_end;
  logic [CELL_W-1:0] cell_now;

  assign w_eff     = eff_side(width_r);
  assign h_eff     = eff_side(height_r);
  assign col_inc   = SIDE_W'(col_r) + 1'b1;
  assign row_inc   = SIDE_W'(row_r) + 1'b1;
  assign row_end   = (col_inc >= w_eff);
  assign stat.frame_end = row_end && (row_inc >= h_eff);
  assign cell_now  = {cell_of(row_r, h_eff), cell_of(col_r, w_eff)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= stat.frame_end ? '0 : POS_W'(row_inc);
      end else begin
        col_r <= POS_W'(col_inc);
      end
    end
  end

  // luma of the accepted pixel, folded into its cell next cycle
  logic              acc_vld_r;
  logic [CELL_W-1:0] cell_r;
  logic [LUMA_W-1:0] luma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) acc_vld_r <= 1'b0;
    else        acc_vld_r <= cmd.accept;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_r <= cell_now;
      luma_r <= LUMA_W'(WEIGHT_R) * LUMA_W'(in_red)
              + LUMA_W'(WEIGHT_G) * LUMA_W'(in_green)
              + LUMA_W'(WEIGHT_B) * LUMA_W'(in_blue);
    end
  end

  // per-cell sums and counts, one read port shared by fold and readout
  logic [SUM_W-1:0]  sum_r [CELLS];
  logic [CNT_W-1:0]  cnt_r [CELLS];
  logic [CELL_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;

  assign rd_addr = cmd.load ? cmd.cell_k : cell_r;
  assign rd_sum  = sum_r[rd_addr];
  assign rd_cnt  = cnt_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (cmd.load) begin
      sum_r[rd_addr] <= '0;
      cnt_r[rd_addr] <= '0;
    end else if (acc_vld_r) begin
      sum_r[rd_addr] <= rd_sum + SUM_W'(luma_r);
      cnt_r[rd_addr] <= rd_cnt + 1'b1;
    end
  end

  // restoring divider: quotient of (sum + den/2) / den, den = 255 * count
  logic [DEN_W-1:0] den_r;
  logic [REM_W-1:0] rem_r, dsh_r;
  logic [Q_W-1:0]   q_r;
  logic             empty_r;
  logic             ge;
  logic [Q_W-1:0]   mean;

  assign ge   = (rem_r >= dsh_r);
  assign mean = empty_r ? '0 : ((q_r > Q_ONE) ? Q_ONE : q_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r   <= (DEN_W'(rd_cnt) << 8) - DEN_W'(rd_cnt);
      rem_r   <= REM_W'(rd_sum);
      empty_r <= (rd_cnt == '0);
    end else if (cmd.prep) begin
      rem_r <= rem_r + REM_W'(den_r >> 1);
      dsh_r <= REM_W'(den_r) << (Q_W - 1);
      q_r   <= '0;
    end else if (cmd.step) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  // result registers
  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_index_r;
  logic [Q_W-1:0]    out_mean_luma_r;
  logic              out_last_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cell_index_r <= cmd.cell_k;
      out_mean_luma_r  <= mean;
      out_last_cell_r  <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_cell_index_r;
  assign out_mean_luma  = out_mean_luma_r;
  assign out_last_cell  = out_last_cell_r;

endmodule

>>> rtl/grid_luma_signature.sv
// Top level of the grid luma signature block: controller plus datapath.
// Depends on glsig_pkg, glsig_ctrl and glsig_dp.
//
// Pixels arrive in raster order as requests on start/busy, one per cycle
// while busy is low; each is placed in a 4x4 grid cell from the column and
// row counters and the configured width and height, and its BT.709 luma
// (16-bit weights) is added to that cell. The frame's last pixel raises
// busy while that pixel is folded in and then, for each cell in turn, the
// shared restoring divider loads, prepares, runs its 17 steps and emits.
// Sixteen results follow, cell 0 first, the last of them in the cycle in
// which busy falls. Each result is shown for exactly one cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// mean_luma is the cell's mean luma in Q.16 (65536 is full scale), halves
// rounded up, 0 for an empty cell. A width or height of 0 counts as 1, any
// value above MAX_SIDE as MAX_SIDE. cfg_ready is always high; write size
// registers only while busy is low and no result is pending.
module grid_luma_signature #(
  parameter int MAX_SIDE = glsig_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [glsig_pkg::CH_W-1:0]      in_red,
  input  logic [glsig_pkg::CH_W-1:0]      in_green,
  input  logic [glsig_pkg::CH_W-1:0]      in_blue,
  output logic                            out_valid,
  output logic [glsig_pkg::CELL_W-1:0]    out_cell_index,
  output logic [glsig_pkg::Q_W-1:0]       out_mean_luma,
  output logic                            out_last_cell,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glsig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [glsig_pkg::CFG_W-1:0]     cfg_data
);
  import glsig_pkg::*;

  glsig_cmd_t  cmd;
  glsig_stat_t stat;

  // size writes are always taken
  assign cfg_ready = 1'b1;

  glsig_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  glsig_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_cell_index (out_cell_index),
    .out_mean_luma  (out_mean_luma),
    .out_last_cell  (out_last_cell)
  );

endmodule

>>> rtl/glsig_chk.sv
// Port-level checker for the grid luma signature block, bound to the top.
// Depends on glsig_pkg and grid_luma_signature.
module glsig_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         busy,
  input logic                         out_valid,
  input logic [glsig_pkg::CELL_W-1:0] out_cell_index,
  input logic [glsig_pkg::Q_W-1:0]    out_mean_luma,
  input logic                         out_last_cell
);
  import glsig_pkg::*;

  // results are spaced by the divider, never in adjacent cycles
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_cell) |-> (out_cell_index == CELL_LAST))
    else $error("last cell flag on wrong cell");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean_luma <= Q_ONE))
    else $error("mean above full scale");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_cell) |-> busy)
    else $error("readout left before last cell");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last_cell))
    else $error("busy fell without last result");

endmodule

bind grid_luma_signature glsig_chk u_glsig_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_cell_index (out_cell_index),
  .out_mean_luma  (out_mean_luma),
  .out_last_cell  (out_last_cell)
);
